// ===== rtl/core/hssp_pkg.sv =====
// ----------------------------------------------------------------------------
// hssp_pkg: shared types and constants for the half-step stepper positioner
// Holds the transfer payload structs, item and direction codes, register
// indexes and the half-step coil table.
// ----------------------------------------------------------------------------
package hssp_pkg;

  localparam int POS_BITS   = 10;
  localparam int DELAY_BITS = 16;
  localparam int CFG_BITS   = 16;

  // Item kinds
  localparam logic [1:0] FUNC_TICK      = 2'd0;
  localparam logic [1:0] FUNC_GOTO      = 2'd1;
  localparam logic [1:0] FUNC_SET_PHASE = 2'd2;

  // Motion directions
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_STEP_DELAY    = 2'd0;
  localparam logic [1:0] CFG_LIMIT_CW_END  = 2'd1;
  localparam logic [1:0] CFG_LIMIT_CCW_END = 2'd2;

  // Configuration reset values
  localparam logic [DELAY_BITS-1:0] STEP_DELAY_RST    = DELAY_BITS'(10);
  localparam logic [POS_BITS-1:0]   LIMIT_CW_END_RST  = POS_BITS'(50);
  localparam logic [POS_BITS-1:0]   LIMIT_CCW_END_RST = POS_BITS'(973);

  localparam logic [3:0] COILS_OFF = 4'b0000;

  typedef struct packed {
    logic [1:0]          func;
    logic [POS_BITS-1:0] sample;
    logic [POS_BITS-1:0] goal;
    logic [2:0]          new_phase;
  } in_item_t;

  typedef struct packed {
    logic [3:0]          coils;
    logic [1:0]          moving_dir;
    logic [POS_BITS-1:0] last_position;
    logic                done_res;
    logic                limit_stop;
  } out_item_t;

  typedef struct packed {
    logic [DELAY_BITS-1:0] step_delay;
    logic [POS_BITS-1:0]   limit_cw_end;
    logic [POS_BITS-1:0]   limit_ccw_end;
  } cfg_t;

  // Half-step coil pattern, bit0 coil A .. bit3 coil D
  function automatic logic [3:0] phase_coils(input logic [2:0] phase);
    logic [3:0] pat;
    case (phase)
      3'd0:    pat = 4'b0001;
      3'd1:    pat = 4'b0011;
      3'd2:    pat = 4'b0010;
      3'd3:    pat = 4'b0110;
      3'd4:    pat = 4'b0100;
      3'd5:    pat = 4'b1100;
      3'd6:    pat = 4'b1000;
      default: pat = 4'b1001;
    endcase
    return pat;
  endfunction

endpackage

// ===== rtl/core/hssp_cfg.sv =====
// ----------------------------------------------------------------------------
// hssp_cfg: configuration registers
// Takes register writes from the configuration channel and holds the step
// interval and the two end limits.
// ----------------------------------------------------------------------------
module hssp_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [hssp_pkg::CFG_BITS-1:0] cfg_data,
  output hssp_pkg::cfg_t                cfg
);
  import hssp_pkg::*;

  // Always take a write
  assign cfg_ready = 1'b1;

  // Update the addressed register; drop writes to unused indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_delay    <= STEP_DELAY_RST;
      cfg.limit_cw_end  <= LIMIT_CW_END_RST;
      cfg.limit_ccw_end <= LIMIT_CCW_END_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEP_DELAY:    cfg.step_delay    <= cfg_data[DELAY_BITS-1:0];
        CFG_LIMIT_CW_END:  cfg.limit_cw_end  <= cfg_data[POS_BITS-1:0];
        CFG_LIMIT_CCW_END: cfg.limit_ccw_end <= cfg_data[POS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/hssp_core.sv =====
// ----------------------------------------------------------------------------
// hssp_core: positioner state and step decision
// Holds the motion state and works out, for one item, the next state and the
// result in a single pass of combinational logic.
// ----------------------------------------------------------------------------
module hssp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  hssp_pkg::in_item_t  item,
  input  hssp_pkg::cfg_t      cfg,
  output hssp_pkg::out_item_t result
);
  import hssp_pkg::*;

  logic [POS_BITS-1:0]   held_position, held_position_next;
  logic [POS_BITS-1:0]   target_position, target_position_next;
  logic [2:0]            phase_index, phase_index_next;
  logic [1:0]            direction, direction_next;
  logic [DELAY_BITS-1:0] delay_left, delay_left_next;
  logic [3:0]            coil_pattern, coil_pattern_next;
  logic                  done_flag, lim_flag;

  logic [DELAY_BITS-1:0] delay_dec;
  logic                  go_on;
  logic                  inside_limits;

  // Count down without wrap
  assign delay_dec = (delay_left != '0) ? delay_left - DELAY_BITS'(1) : '0;

  // Keep moving until the target is passed
  assign go_on = ((direction == DIR_CW)  && (item.sample >= target_position)) ||
                 ((direction == DIR_CCW) && (item.sample <= target_position));

  assign inside_limits = (item.sample > cfg.limit_cw_end) &&
                         (item.sample < cfg.limit_ccw_end);

  // Next state for the item in the input register
  always_comb begin
    held_position_next   = held_position;
    target_position_next = target_position;
    phase_index_next     = phase_index;
    direction_next       = direction;
    delay_left_next      = delay_left;
    coil_pattern_next    = coil_pattern;
    done_flag            = 1'b0;
    lim_flag             = 1'b0;

    case (item.func)
      FUNC_TICK: begin
        delay_left_next = delay_dec;
        if (delay_dec == '0) begin
          held_position_next = item.sample;
          if (!go_on) begin
            // Target passed: switch off and flag done
            if (direction != DIR_NONE) begin
              direction_next    = DIR_NONE;
              coil_pattern_next = COILS_OFF;
              done_flag         = 1'b1;
            end
          end else begin
            delay_left_next = cfg.step_delay;
            // Step the phase unless the end limit in the travel direction is hit
            if (direction == DIR_CCW) begin
              if (item.sample < cfg.limit_ccw_end) begin
                phase_index_next = phase_index - 3'd1;
              end else begin
                direction_next = DIR_NONE;
                lim_flag       = 1'b1;
              end
            end else begin
              if (item.sample > cfg.limit_cw_end) begin
                phase_index_next = phase_index + 3'd1;
              end else begin
                direction_next = DIR_NONE;
                lim_flag       = 1'b1;
              end
            end
            // Drive the new phase only strictly inside both limits
            if (direction_next != DIR_NONE && inside_limits) begin
              coil_pattern_next = phase_coils(phase_index_next);
            end else begin
              direction_next    = DIR_NONE;
              coil_pattern_next = COILS_OFF;
              lim_flag          = 1'b1;
            end
          end
        end
      end
      FUNC_GOTO: begin
        held_position_next = item.sample;
        if (item.sample != item.goal) begin
          target_position_next = item.goal;
          delay_left_next      = cfg.step_delay;
          if (item.goal > item.sample) begin
            direction_next   = DIR_CCW;
            phase_index_next = 3'd7;
          end else begin
            direction_next   = DIR_CW;
            phase_index_next = 3'd0;
          end
        end
      end
      FUNC_SET_PHASE: begin
        phase_index_next = item.new_phase;
      end
      default: begin
      end
    endcase
  end

  // Result shows the state after the item
  always_comb begin
    result.coils         = coil_pattern_next;
    result.moving_dir    = direction_next;
    result.last_position = held_position_next;
    result.done_res      = done_flag;
    result.limit_stop    = lim_flag;
  end

  // Commit the state when the item moves to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_position   <= '0;
      target_position <= '0;
      phase_index     <= '0;
      direction       <= DIR_NONE;
      delay_left      <= '0;
      coil_pattern    <= COILS_OFF;
    end else if (advance) begin
      held_position   <= held_position_next;
      target_position <= target_position_next;
      phase_index     <= phase_index_next;
      direction       <= direction_next;
      delay_left      <= delay_left_next;
      coil_pattern    <= coil_pattern_next;
    end
  end

endmodule

// ===== rtl/core/half_step_stepper_positioner.sv =====
// An item is held in the input register and its result in the output register.
// Throughput: one item per cycle unless out_ready holds the output; an item is decided
// in one pass between the input register and the output register, which parts the two channels.
// Reset (rst, synchronous, active high): motor off, phase 0, positions and
// delay cleared, registers back to 10 ticks, 50 and 973, both channels empty.
// ----------------------------------------------------------------------------
// half_step_stepper_positioner: top level of one positioner channel
// Input register, decision core, output register and configuration registers.
// ----------------------------------------------------------------------------
module half_step_stepper_positioner (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hssp_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hssp_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [hssp_pkg::CFG_BITS-1:0] cfg_data
);
  import hssp_pkg::*;

  logic      stage_valid;
  in_item_t  stage_item;
  logic      out_load;
  cfg_t      cfg;
  out_item_t result;

  // Move the staged item on when the output register is free or drains
  assign out_load = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || out_load;

  hssp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hssp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (out_load),
    .item    (stage_item),
    .cfg     (cfg),
    .result  (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_pulses_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.done_res && out_data.limit_stop))
    else $error("done and limit stop pulsed together");

  a_stop_coils_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.done_res || out_data.limit_stop) |->
      (out_data.coils == COILS_OFF) && (out_data.moving_dir == DIR_NONE))
    else $error("motor not switched off on stop");

  a_idle_coils_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.moving_dir == DIR_NONE) |-> (out_data.coils == COILS_OFF))
    else $error("coils driven with no direction");

  a_stage_fill: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> stage_valid)
    else $error("accepted item not staged");
`endif

endmodule
